/* rtl/vocst_pkg.sv */
// ----------------------------------------------------------------------------
// vocst_pkg
// Shared types, codes and reset values for the valve open/close self test.
// ----------------------------------------------------------------------------
package vocst_pkg;

    // Input command, carried on s_tuser
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_OPEN  = 2'd1,
        CMD_CLOSE = 2'd2
    } cmd_t;

    // Request source
    localparam logic [1:0] SRC_NORMAL_OPEN = 2'd0;
    localparam logic [1:0] SRC_NORMAL_OFF  = 2'd1;
    localparam logic [1:0] SRC_OTHER_OPEN  = 2'd2;
    localparam logic [1:0] SRC_OTHER_OFF   = 2'd3;

    // Request status
    localparam logic [2:0] ST_NONE        = 3'd0;
    localparam logic [2:0] ST_OPENED      = 3'd1;
    localparam logic [2:0] ST_CLOSED      = 3'd2;
    localparam logic [2:0] ST_OPEN_DENY   = 3'd3;
    localparam logic [2:0] ST_CLOSE_DENY  = 3'd4;
    localparam logic [2:0] ST_OTHER_OFF   = 3'd5;

    // Alarm clear source
    localparam logic [1:0] CLR_NONE  = 2'd0;
    localparam logic [1:0] CLR_LEFT  = 2'd1;
    localparam logic [1:0] CLR_RIGHT = 2'd2;

    // Gateway report
    localparam logic [1:0] RPT_NONE  = 2'd0;
    localparam logic [1:0] RPT_OPEN  = 2'd1;
    localparam logic [1:0] RPT_CLOSE = 2'd2;

    // Timer indexes
    localparam int T_SAMPLE  = 0;
    localparam int T_TIMEOUT = 1;
    localparam int T_LFINAL  = 2;
    localparam int T_RFINAL  = 3;
    localparam int T_DELAY   = 4;

    // Register word indexes (paddr[4:2])
    localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
    localparam logic [2:0] REG_CHECK_TIMEOUT = 3'd1;
    localparam logic [2:0] REG_LEFT_FINAL    = 3'd2;
    localparam logic [2:0] REG_RIGHT_FINAL   = 3'd3;
    localparam logic [2:0] REG_TEST_DELAY    = 3'd4;
    localparam logic [2:0] REG_LOW_NEEDED    = 3'd5;

    localparam int AddrWidth = 5;

    // Register reset values
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd500;
    localparam logic [15:0] RST_CHECK_TIMEOUT = 16'd10000;
    localparam logic [15:0] RST_LEFT_FINAL    = 16'd10000;
    localparam logic [15:0] RST_RIGHT_FINAL   = 16'd10100;
    localparam logic [19:0] RST_TEST_DELAY    = 20'(60 * 1000 * 5);
    localparam logic [3:0]  RST_LOW_NEEDED    = 4'd3;

    localparam logic [4:0] LOW_COUNT_MAX = 5'd31;

    // Result item; last member lands in the lowest bits
    typedef struct packed {
        logic [1:0] gateway_report;
        logic [1:0] alarm_cleared;
        logic       right_alarm_raised;
        logic       left_alarm_raised;
        logic [2:0] request_status;
        logic       right_failed;
        logic       left_failed;
        logic       valve_is_open;
        logic       drive_right;
        logic       drive_left;
    } result_t;

endpackage

/* rtl/valve_open_close_self_test.sv */
// ----------------------------------------------------------------------------
// valve_open_close_self_test
// Two-motor valve controller with a delayed motor self test.
//
// Input stream: one transfer per 1 ms tick, open request or close request.
// The command rides on s_tuser, source and sensor levels on s_tdata. Every
// input transfer produces exactly one result transfer on the m_ side with
// drive levels, valve state, fail flags, request status and events.
// Throughput is one transfer per cycle while s_tready is high: the whole update
// of the controller state is one pass of logic from the state registers and the
// input beat into the state registers and the result register.
// The result side is a two-entry buffer (result register plus skid); when
// the receiver stalls, one more item is taken and then s_tready drops until
// the receiver takes the head result. s_tready depends on registers only.
// The user is to write configuration over the APB port only while the stream
// is idle; the block itself does not enforce this. Reset clears all controller
// state and loads the default timing values; s_tready is high out of reset, so
// an input transfer can be taken once reset is released.
// ----------------------------------------------------------------------------
module valve_open_close_self_test
    import vocst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // slave stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // act_source[1:0], sensor_left, sensor_right
    input  logic [1:0]           s_tuser,   // command
    // master stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // drive_left, drive_right, valve_is_open,
                                            // left_failed, right_failed,
                                            // request_status[2:0], left_alarm_raised,
                                            // right_alarm_raised, alarm_cleared[1:0],
                                            // gateway_report[1:0]
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // configuration registers
    logic [15:0] sample_period_reg;
    logic [15:0] check_timeout_reg;
    logic [15:0] left_final_reg;
    logic [15:0] right_final_reg;
    logic [19:0] test_delay_reg;
    logic [3:0]  low_needed_reg;

    // controller state
    logic [1:0]  last_source_reg, last_source_next;
    logic        open_reg, open_next;
    logic [1:0]  drive_reg, drive_next;
    logic [1:0]  chk_reg, chk_next;
    logic [1:0]  pass_reg, pass_next;
    logic [1:0]  fail_reg, fail_next;
    logic [4:0]  low_cnt_reg [2];
    logic [4:0]  low_cnt_next [2];
    logic [4:0]  active_reg, active_next;
    logic [15:0] tcnt_reg [4];
    logic [15:0] tcnt_next [4];
    logic [19:0] dcnt_reg, dcnt_next;

    // result buffer
    result_t     head_reg, skid_reg, result;
    logic        head_valid_reg, skid_valid_reg;

    logic        accept;
    logic        pop;
    logic        cfg_write;
    cmd_t        cmd;
    logic [1:0]  src;
    logic [1:0]  sens;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    // ------------------------------------------------------------------
    // APB registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= RST_SAMPLE_PERIOD;
            check_timeout_reg <= RST_CHECK_TIMEOUT;
            left_final_reg    <= RST_LEFT_FINAL;
            right_final_reg   <= RST_RIGHT_FINAL;
            test_delay_reg    <= RST_TEST_DELAY;
            low_needed_reg    <= RST_LOW_NEEDED;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_SAMPLE_PERIOD: sample_period_reg <= pwdata[15:0];
                REG_CHECK_TIMEOUT: check_timeout_reg <= pwdata[15:0];
                REG_LEFT_FINAL:    left_final_reg    <= pwdata[15:0];
                REG_RIGHT_FINAL:   right_final_reg   <= pwdata[15:0];
                REG_TEST_DELAY:    test_delay_reg    <= pwdata[19:0];
                REG_LOW_NEEDED:    low_needed_reg    <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_SAMPLE_PERIOD: prdata = {16'd0, sample_period_reg};
            REG_CHECK_TIMEOUT: prdata = {16'd0, check_timeout_reg};
            REG_LEFT_FINAL:    prdata = {16'd0, left_final_reg};
            REG_RIGHT_FINAL:   prdata = {16'd0, right_final_reg};
            REG_TEST_DELAY:    prdata = {12'd0, test_delay_reg};
            REG_LOW_NEEDED:    prdata = {28'd0, low_needed_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller update
    // ------------------------------------------------------------------
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign pop      = head_valid_reg & m_tready;

    assign cmd  = cmd_t'(s_tuser);
    assign src  = s_tdata[1:0];
    assign sens = s_tdata[3:2];

    always_comb
    begin
        logic [4:0] expired;
        logic [1:0] alarm;
        logic [1:0] clr;
        logic [2:0] status;
        logic [1:0] report;
        logic [1:0] b;

        last_source_next = last_source_reg;
        open_next        = open_reg;
        drive_next       = drive_reg;
        chk_next         = chk_reg;
        pass_next        = pass_reg;
        fail_next        = fail_reg;
        low_cnt_next     = low_cnt_reg;
        active_next      = active_reg;
        tcnt_next        = tcnt_reg;
        dcnt_next        = dcnt_reg;
        expired          = '0;
        alarm            = '0;
        clr              = CLR_NONE;
        status           = ST_NONE;
        report           = RPT_NONE;
        b                = '0;

        case (cmd)
            CMD_TICK:
            begin
                // count down every running timer
                for (int t = 0; t < 4; t++)
                begin
                    if (active_reg[t])
                    begin
                        if (tcnt_reg[t] <= 16'd1)
                        begin
                            expired[t]   = 1'b1;
                            tcnt_next[t] = '0;
                        end
                        else
                        begin
                            tcnt_next[t] = tcnt_reg[t] - 16'd1;
                        end
                    end
                end
                if (active_reg[T_DELAY])
                begin
                    if (dcnt_reg <= 20'd1)
                    begin
                        expired[T_DELAY] = 1'b1;
                        dcnt_next        = '0;
                    end
                    else
                    begin
                        dcnt_next = dcnt_reg - 20'd1;
                    end
                end
                active_next = active_next & ~(expired & 5'b11110);

                // sample: periodic, reloads
                if (expired[T_SAMPLE])
                begin
                    tcnt_next[T_SAMPLE] = sample_period_reg;
                    for (int s = 0; s < 2; s++)
                    begin
                        if (chk_next[s] && !pass_next[s])
                        begin
                            if (!sens[s])
                            begin
                                if (low_cnt_next[s] < LOW_COUNT_MAX)
                                    low_cnt_next[s] = low_cnt_next[s] + 5'd1;
                            end
                            else
                            begin
                                low_cnt_next[s] = '0;
                            end
                            if (low_cnt_next[s] > {1'b0, low_needed_reg})
                            begin
                                chk_next[s]   = 1'b0;
                                pass_next[s]  = 1'b1;
                                drive_next[s] = 1'b1;
                                if (s == 0)
                                begin
                                    active_next[T_LFINAL] = 1'b1;
                                    tcnt_next[T_LFINAL]   = left_final_reg;
                                end
                                else
                                begin
                                    active_next[T_RFINAL] = 1'b1;
                                    tcnt_next[T_RFINAL]   = right_final_reg;
                                end
                            end
                        end
                    end
                    if (chk_next == 2'b00)
                        active_next[T_SAMPLE] = 1'b0;
                end

                // timeout: unfinished sides fail
                if (expired[T_TIMEOUT])
                begin
                    for (int s = 0; s < 2; s++)
                    begin
                        if (chk_next[s] && !pass_next[s])
                        begin
                            fail_next[s]          = 1'b1;
                            chk_next[s]           = 1'b0;
                            alarm[s]              = 1'b1;
                            drive_next[s]         = 1'b1;
                            active_next[T_SAMPLE] = 1'b0;
                        end
                    end
                end

                // final sensor checks, left then right
                for (int s = 0; s < 2; s++)
                begin
                    if (expired[T_LFINAL + s])
                    begin
                        b = 2'(1 << s);
                        if (sens[s])
                        begin
                            fail_next[s] = 1'b0;
                            if ((fail_next & ~b) == 2'b00)
                                clr = (s == 0) ? CLR_LEFT : CLR_RIGHT;
                        end
                        else
                        begin
                            fail_next[s] = 1'b1;
                            alarm[s]     = 1'b1;
                        end
                    end
                end

                // test delay: if open, start the low check on sides reading high
                if (expired[T_DELAY] && open_reg)
                begin
                    low_cnt_next[0] = '0;
                    low_cnt_next[1] = '0;
                    chk_next        = '0;
                    pass_next       = '0;
                    active_next     = '0;
                    for (int s = 0; s < 2; s++)
                    begin
                        if (sens[s])
                        begin
                            chk_next[s]            = 1'b1;
                            drive_next[s]          = 1'b0;
                            active_next[T_SAMPLE]  = 1'b1;
                            tcnt_next[T_SAMPLE]    = sample_period_reg;
                            active_next[T_TIMEOUT] = 1'b1;
                            tcnt_next[T_TIMEOUT]   = check_timeout_reg;
                        end
                    end
                end
            end

            CMD_OPEN:
            begin
                if (last_source_reg != SRC_OTHER_OFF || src == SRC_OTHER_OPEN)
                begin
                    open_next        = 1'b1;
                    last_source_next = src;
                    drive_next       = 2'b11;
                    active_next[3:0] = 4'b0000;
                    if (src == SRC_NORMAL_OPEN)
                    begin
                        report               = RPT_OPEN;
                        active_next[T_DELAY] = 1'b1;
                        dcnt_next            = test_delay_reg;
                    end
                    status = ST_OPENED;
                end
                else if (src == SRC_NORMAL_OPEN)
                begin
                    status = ST_OPEN_DENY;
                end
            end

            CMD_CLOSE:
            begin
                if (last_source_reg != SRC_OTHER_OFF)
                begin
                    open_next        = 1'b0;
                    last_source_next = src;
                    if (src == SRC_NORMAL_OFF)
                        report = RPT_CLOSE;
                    drive_next  = 2'b00;
                    active_next = '0;
                    status      = ST_CLOSED;
                end
                else if (src == SRC_OTHER_OFF)
                begin
                    open_next = 1'b0;
                    status    = ST_OTHER_OFF;
                end
                else
                begin
                    status = ST_CLOSE_DENY;
                end
            end

            default: ;
        endcase

        result.drive_left         = drive_next[0];
        result.drive_right        = drive_next[1];
        result.valve_is_open      = open_next;
        result.left_failed        = fail_next[0];
        result.right_failed       = fail_next[1];
        result.request_status     = status;
        result.left_alarm_raised  = alarm[0];
        result.right_alarm_raised = alarm[1];
        result.alarm_cleared      = clr;
        result.gateway_report     = report;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_source_reg <= SRC_NORMAL_OFF;
            open_reg        <= 1'b0;
            drive_reg       <= '0;
            chk_reg         <= '0;
            pass_reg        <= '0;
            fail_reg        <= '0;
            low_cnt_reg[0]  <= '0;
            low_cnt_reg[1]  <= '0;
            active_reg      <= '0;
            for (int t = 0; t < 4; t++)
                tcnt_reg[t] <= '0;
            dcnt_reg        <= '0;
        end
        else if (accept)
        begin
            last_source_reg <= last_source_next;
            open_reg        <= open_next;
            drive_reg       <= drive_next;
            chk_reg         <= chk_next;
            pass_reg        <= pass_next;
            fail_reg        <= fail_next;
            low_cnt_reg     <= low_cnt_next;
            active_reg      <= active_next;
            tcnt_reg        <= tcnt_next;
            dcnt_reg        <= dcnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: head register plus one skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            head_valid_reg <= skid_valid_reg | accept;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg)
        begin
            head_valid_reg <= accept;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
                head_reg <= skid_reg;
            else if (accept)
                head_reg <= result;
        end
        else if (!head_valid_reg && accept)
        begin
            head_reg <= result;
        end
        else if (head_valid_reg && accept)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = head_valid_reg;
    assign m_tdata  = {2'b00, head_reg};

`ifndef SYNTHESIS
    // skid entry only ever holds the younger of two results
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid with empty head");

    // a side is never checking and passed at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (chk_reg & pass_reg) == 2'b00)
        else $error("side both checking and passed");

    // sample timer runs only while a side is still under low check
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg[T_SAMPLE] |-> (chk_reg != 2'b00))
        else $error("sample timer running with no side checking");

    // a raised alarm always leaves its fail flag set
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg && (head_reg.left_alarm_raised || head_reg.right_alarm_raised))
        |-> ((!head_reg.left_alarm_raised || head_reg.left_failed) &&
             (!head_reg.right_alarm_raised || head_reg.right_failed)))
        else $error("alarm raised without fail flag");
`endif

endmodule

/* tb/valve_open_close_self_test_test.sv */
// ----------------------------------------------------------------------------
// valve_open_close_self_test_test
// Self-checking bench for the two-motor valve controller. A behavioral copy
// of the controller predicts every result transfer; requests and 1 ms ticks
// are driven with random gaps and receiver stalls under several timing
// settings, and the sensor levels follow the predicted drive lines so that
// self tests run to pass, timeout and final-check outcomes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module valve_open_close_self_test_test;
    import vocst_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 1000;

    // simulated motor behavior
    localparam int FAULT_NONE    = 0;
    localparam int FAULT_HIGH    = 1;
    localparam int FAULT_LOW     = 2;
    localparam int FAULT_ERRATIC = 3;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [15:0]          m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [AddrWidth-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // timing settings as last written
    logic [15:0] sample_period_cfg;
    logic [15:0] check_timeout_cfg;
    logic [15:0] left_final_cfg;
    logic [15:0] right_final_cfg;
    logic [19:0] test_delay_cfg;
    logic [3:0]  low_needed_cfg;

    // predicted controller state
    logic [1:0]  req_src_last;
    logic        valve_open;
    logic [1:0]  drive_lines;
    logic [1:0]  check_active;
    logic [1:0]  check_passed;
    logic [1:0]  motor_fail;
    logic [4:0]  low_run [2];
    logic [4:0]  timer_run;
    logic [15:0] timer_left [4];
    logic [19:0] delay_left;
    logic [1:0]  alarm_ev;
    logic [1:0]  clear_ev;

    result_t expected_results [$];

    int  errors;
    int  items_sent;
    int  results_checked;
    int  alarms_seen;
    int  clears_seen;
    int  settings_used;
    int  idle_cycles;
    int  rx_wait;
    bit  no_idle;
    int  motor_fault [2];

    valve_open_close_self_test u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller prediction
    // ------------------------------------------------------------------
    function automatic void reset_valve_state();
        sample_period_cfg = RST_SAMPLE_PERIOD;
        check_timeout_cfg = RST_CHECK_TIMEOUT;
        left_final_cfg    = RST_LEFT_FINAL;
        right_final_cfg   = RST_RIGHT_FINAL;
        test_delay_cfg    = RST_TEST_DELAY;
        low_needed_cfg    = RST_LOW_NEEDED;
        req_src_last      = SRC_NORMAL_OFF;
        valve_open        = 1'b0;
        drive_lines       = 2'b00;
        check_active      = 2'b00;
        check_passed      = 2'b00;
        motor_fail        = 2'b00;
        low_run[0]        = '0;
        low_run[1]        = '0;
        timer_run         = '0;
        for (int t = 0; t < 4; t++)
            timer_left[t] = '0;
        delay_left        = '0;
    endfunction

    function automatic void arm_timer(int idx);
        timer_run[idx] = 1'b1;
        case (idx)
            T_SAMPLE:  timer_left[T_SAMPLE]  = sample_period_cfg;
            T_TIMEOUT: timer_left[T_TIMEOUT] = check_timeout_cfg;
            T_LFINAL:  timer_left[T_LFINAL]  = left_final_cfg;
            T_RFINAL:  timer_left[T_RFINAL]  = right_final_cfg;
            default:   delay_left            = test_delay_cfg;
        endcase
    endfunction

    function automatic void sample_motors(logic [1:0] sens);
        for (int s = 0; s < 2; s++)
        begin
            if (check_active[s] && !check_passed[s])
            begin
                if (!sens[s])
                begin
                    if (low_run[s] != LOW_COUNT_MAX)
                        low_run[s]++;
                end
                else
                    low_run[s] = '0;
                if (low_run[s] > {1'b0, low_needed_cfg})
                begin
                    check_active[s] = 1'b0;
                    check_passed[s] = 1'b1;
                    drive_lines[s]  = 1'b1;
                    arm_timer(s == 0 ? T_LFINAL : T_RFINAL);
                end
            end
        end
        if (check_active == 2'b00)
            timer_run[T_SAMPLE] = 1'b0;
    endfunction

    function automatic void fail_unfinished();
        for (int s = 0; s < 2; s++)
        begin
            if (check_active[s] && !check_passed[s])
            begin
                motor_fail[s]       = 1'b1;
                check_active[s]     = 1'b0;
                alarm_ev[s]         = 1'b1;
                drive_lines[s]      = 1'b1;
                timer_run[T_SAMPLE] = 1'b0;
            end
        end
    endfunction

    function automatic void final_check(int s, logic level);
        if (level)
        begin
            motor_fail[s] = 1'b0;
            if (!motor_fail[1 - s])
                clear_ev = (s == 0) ? CLR_LEFT : CLR_RIGHT;
        end
        else
        begin
            motor_fail[s] = 1'b1;
            alarm_ev[s]   = 1'b1;
        end
    endfunction

    function automatic void start_self_test(logic [1:0] sens);
        if (!valve_open)
            return;
        low_run[0]   = '0;
        low_run[1]   = '0;
        check_active = 2'b00;
        check_passed = 2'b00;
        timer_run    = '0;
        for (int s = 0; s < 2; s++)
        begin
            if (sens[s])
            begin
                check_active[s] = 1'b1;
                drive_lines[s]  = 1'b0;
                arm_timer(T_SAMPLE);
                arm_timer(T_TIMEOUT);
            end
        end
    endfunction

    function automatic void advance_timers(logic [1:0] sens);
        logic [4:0] expired;
        expired = '0;
        for (int t = 0; t < 4; t++)
        begin
            if (timer_run[t])
            begin
                if (timer_left[t] <= 16'd1)
                begin
                    expired[t]    = 1'b1;
                    timer_left[t] = '0;
                end
                else
                    timer_left[t]--;
            end
        end
        if (timer_run[T_DELAY])
        begin
            if (delay_left <= 20'd1)
            begin
                expired[T_DELAY] = 1'b1;
                delay_left       = '0;
            end
            else
                delay_left--;
        end
        for (int t = 1; t < 5; t++)
            if (expired[t])
                timer_run[t] = 1'b0;
        // expiries on one tick run in fixed order
        if (expired[T_SAMPLE])
        begin
            timer_left[T_SAMPLE] = sample_period_cfg;
            sample_motors(sens);
        end
        if (expired[T_TIMEOUT])
            fail_unfinished();
        if (expired[T_LFINAL])
            final_check(0, sens[0]);
        if (expired[T_RFINAL])
            final_check(1, sens[1]);
        if (expired[T_DELAY])
            start_self_test(sens);
    endfunction

    function automatic result_t predict_valve_step(logic [1:0] cmd, logic [1:0] src,
                                                   logic [1:0] sens);
        result_t    r;
        logic [2:0] status;
        logic [1:0] report;
        status   = ST_NONE;
        report   = RPT_NONE;
        alarm_ev = 2'b00;
        clear_ev = CLR_NONE;
        if (cmd == CMD_TICK)
            advance_timers(sens);
        else if (cmd == CMD_OPEN)
        begin
            if (req_src_last != SRC_OTHER_OFF || src == SRC_OTHER_OPEN)
            begin
                valve_open           = 1'b1;
                req_src_last         = src;
                drive_lines          = 2'b11;
                timer_run[T_SAMPLE]  = 1'b0;
                timer_run[T_TIMEOUT] = 1'b0;
                timer_run[T_LFINAL]  = 1'b0;
                timer_run[T_RFINAL]  = 1'b0;
                if (src == SRC_NORMAL_OPEN)
                begin
                    report = RPT_OPEN;
                    arm_timer(T_DELAY);
                end
                status = ST_OPENED;
            end
            else if (src == SRC_NORMAL_OPEN)
                status = ST_OPEN_DENY;
        end
        else if (cmd == CMD_CLOSE)
        begin
            if (req_src_last != SRC_OTHER_OFF)
            begin
                valve_open   = 1'b0;
                req_src_last = src;
                if (src == SRC_NORMAL_OFF)
                    report = RPT_CLOSE;
                drive_lines = 2'b00;
                timer_run   = '0;
                status      = ST_CLOSED;
            end
            else if (src == SRC_OTHER_OFF)
            begin
                valve_open = 1'b0;
                status     = ST_OTHER_OFF;
            end
            else
                status = ST_CLOSE_DENY;
        end
        r.drive_left         = drive_lines[0];
        r.drive_right        = drive_lines[1];
        r.valve_is_open      = valve_open;
        r.left_failed        = motor_fail[0];
        r.right_failed       = motor_fail[1];
        r.request_status     = status;
        r.left_alarm_raised  = alarm_ev[0];
        r.right_alarm_raised = alarm_ev[1];
        r.alarm_cleared      = clear_ev;
        r.gateway_report     = report;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, receiver stalls, watchdog
    // ------------------------------------------------------------------
    task automatic compare_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t want;
        result_t got;
        if (rst_n)
        begin
            // pop before push: a result always belongs to an earlier transfer
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[13:0]);
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("drive_left", want.drive_left, got.drive_left);
                    compare_field("drive_right", want.drive_right, got.drive_right);
                    compare_field("valve_is_open", want.valve_is_open, got.valve_is_open);
                    compare_field("left_failed", want.left_failed, got.left_failed);
                    compare_field("right_failed", want.right_failed, got.right_failed);
                    compare_field("request_status", want.request_status,
                                  got.request_status);
                    compare_field("left_alarm_raised", want.left_alarm_raised,
                                  got.left_alarm_raised);
                    compare_field("right_alarm_raised", want.right_alarm_raised,
                                  got.right_alarm_raised);
                    compare_field("alarm_cleared", want.alarm_cleared, got.alarm_cleared);
                    compare_field("gateway_report", want.gateway_report,
                                  got.gateway_report);
                    compare_field("tdata padding", 0, m_tdata[15:14]);
                    results_checked++;
                    if (want.left_alarm_raised || want.right_alarm_raised)
                        alarms_seen++;
                    if (want.alarm_cleared != CLR_NONE)
                        clears_seen++;
                end
                rx_wait = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_valve_step(s_tuser, s_tdata[1:0],
                                                              s_tdata[3:2]));
        end
    end

    always @(negedge clk)
    begin
        if (rx_wait > 0)
        begin
            m_tready <= 1'b0;
            rx_wait--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(logic [1:0] cmd, logic [1:0] src, logic sl, logic sr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, sr, sl, src};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic send_random_item(bit requests_only);
        logic [1:0] cmd;
        cmd = requests_only ? 2'($urandom_range(1, 2)) : 2'($urandom_range(0, 3));
        send_item(cmd, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
    endtask

    // sensor levels follow the predicted drive lines unless the motor is faulty
    task automatic send_tick();
        logic [1:0] sens;
        for (int s = 0; s < 2; s++)
        begin
            case (motor_fault[s])
                FAULT_NONE: sens[s] = drive_lines[s] ^ ($urandom_range(0, 7) == 0);
                FAULT_HIGH: sens[s] = 1'b1;
                FAULT_LOW:  sens[s] = 1'b0;
                default:    sens[s] = 1'($urandom);
            endcase
        end
        send_item(CMD_TICK, SRC_NORMAL_OPEN, sens[0], sens[1]);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_SAMPLE_PERIOD: sample_period_cfg = value[15:0];
            REG_CHECK_TIMEOUT: check_timeout_cfg = value[15:0];
            REG_LEFT_FINAL:    left_final_cfg    = value[15:0];
            REG_RIGHT_FINAL:   right_final_cfg   = value[15:0];
            REG_TEST_DELAY:    test_delay_cfg    = value[19:0];
            default:           low_needed_cfg    = value[3:0];
        endcase
    endtask

    task automatic apply_timing(int sp, int to, int lf, int rf, int td, int ln);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        write_reg(REG_SAMPLE_PERIOD, sp);
        write_reg(REG_CHECK_TIMEOUT, to);
        write_reg(REG_LEFT_FINAL, lf);
        write_reg(REG_RIGHT_FINAL, rf);
        write_reg(REG_TEST_DELAY, td);
        write_reg(REG_LOW_NEEDED, ln);
        settings_used++;
    endtask

    // normal open followed by ticks; the odd stray request lands mid-run
    task automatic run_self_test();
        int n_ticks;
        n_ticks = $urandom_range(8, 40);
        for (int s = 0; s < 2; s++)
            motor_fault[s] = ($urandom_range(0, 9) < 7) ? FAULT_NONE :
                             $urandom_range(FAULT_HIGH, FAULT_ERRATIC);
        if (req_src_last == SRC_OTHER_OFF)
            send_item(CMD_OPEN, SRC_OTHER_OPEN, 1'($urandom), 1'($urandom));
        send_item(CMD_OPEN, SRC_NORMAL_OPEN, 1'($urandom), 1'($urandom));
        repeat (n_ticks)
        begin
            if ($urandom_range(0, 19) == 0)
                send_random_item(1'b1);
            else
                send_tick();
        end
    endtask

    task automatic random_traffic(int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    run_self_test();
                6, 7:
                    repeat ($urandom_range(2, 6)) send_random_item(1'b1);
                default:
                    repeat ($urandom_range(1, 8)) send_random_item(1'b0);
            endcase
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_OPEN, SRC_NORMAL_OPEN, 1'b1, 1'b0);
        send_item(CMD_TICK, SRC_OTHER_OFF, 1'b0, 1'b1);
        send_item(CMD_TICK, SRC_OTHER_OPEN, 1'b1, 1'b1);
        send_item(CMD_CLOSE, SRC_NORMAL_OFF, 1'b0, 1'b0);
        send_item(CMD_OPEN, SRC_OTHER_OPEN, 1'b1, 1'b1);
        send_item(CMD_CLOSE, SRC_OTHER_OFF, 1'b0, 1'b0);
        send_item(CMD_TICK, SRC_NORMAL_OFF, 1'b1, 1'b0);
    endtask

    task automatic test_directed_requests();
        // one-tick sampling, equal final delays, pass on the first low sample
        apply_timing(1, 6, 2, 2, 2, 0);
        send_item(CMD_UNUSED, SRC_OTHER_OFF, 1'b1, 1'b1);
        // both sides pass together, both final checks on one tick
        send_item(CMD_OPEN, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b0, 1'b0);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        // left passes but its final check sees low; right never goes low
        send_item(CMD_OPEN, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b0, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b0, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_TICK, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        // permission rules after an other-source close
        send_item(CMD_CLOSE, SRC_OTHER_OFF, 1'b0, 1'b0);
        send_item(CMD_OPEN, SRC_NORMAL_OPEN, 1'b0, 1'b0);
        send_item(CMD_OPEN, SRC_NORMAL_OFF, 1'b0, 1'b0);
        send_item(CMD_CLOSE, SRC_NORMAL_OPEN, 1'b0, 1'b0);
        send_item(CMD_CLOSE, SRC_OTHER_OPEN, 1'b0, 1'b0);
        send_item(CMD_CLOSE, SRC_OTHER_OFF, 1'b0, 1'b0);
        send_item(CMD_OPEN, SRC_OTHER_OPEN, 1'b1, 1'b1);
        send_item(CMD_OPEN, SRC_NORMAL_OPEN, 1'b1, 1'b1);
        send_item(CMD_CLOSE, SRC_NORMAL_OFF, 1'b1, 1'b1);
    endtask

    task automatic test_min_timing();
        // zero sample period acts as one; timeout lands on the first sample
        apply_timing(0, 1, 1, 1, 1, 0);
        random_traffic(60);
    endtask

    task automatic test_random_timing();
        repeat (3)
        begin
            apply_timing($urandom_range(1, 3), $urandom_range(6, 30), $urandom_range(1, 12),
                         $urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 4));
            random_traffic(80);
        end
    endtask

    task automatic test_slow_pass();
        // sixteen lows in a row needed before a side passes
        apply_timing(1, 200, 5, 5, 3, 15);
        random_traffic(60);
    endtask

    task automatic test_max_timing();
        apply_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 15);
        random_traffic(30);
    endtask

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_TICK;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors          = 0;
        items_sent      = 0;
        results_checked = 0;
        alarms_seen     = 0;
        clears_seen     = 0;
        settings_used   = 1;
        idle_cycles     = 0;
        rx_wait         = 0;
        no_idle         = 1'b0;
        motor_fault[0]  = FAULT_NONE;
        motor_fault[1]  = FAULT_NONE;
        reset_valve_state();
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_requests();
        test_min_timing();
        test_random_timing();
        test_slow_pass();
        test_max_timing();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);

        $display("Checked %0d results from %0d requests and ticks under %0d timing settings",
                 results_checked, items_sent, settings_used);
        $display("Self tests raised %0d alarms and %0d clears", alarms_seen, clears_seen);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
